@@ hw/rtl/cdeq_pkg.sv @@
// Shared types and codes for the circular deque block.
// No dependencies; imported by the control, store and top-level modules.
`timescale 1ns / 1ps
`default_nettype none

package cdeq_pkg;

    // operation codes carried in the input beat
    localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
    localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
    localparam logic [2:0] OP_POP_FRONT  = 3'd2;
    localparam logic [2:0] OP_POP_BACK   = 3'd3;
    localparam logic [2:0] OP_RD_FRONT   = 3'd4;
    localparam logic [2:0] OP_RD_BACK    = 3'd5;
    localparam logic [2:0] OP_RD_INDEX   = 3'd6;
    localparam logic [2:0] OP_CLEAR      = 3'd7;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;
    localparam logic [1:0] ST_RANGE = 2'd3;

    localparam int ID_W      = 32;
    localparam int NAME_LO_W = 64;
    localparam int NAME_HI_W = 16;
    localparam int ENTRY_W   = ID_W + NAME_LO_W + NAME_HI_W;
    localparam int FILL_W    = 5;
    localparam int TDATA_W   = 120;

    // per-beat result info from the pointer logic
    typedef struct packed {
        logic              have_read;
        logic [FILL_W-1:0] fill_count;
        logic [1:0]        status;
    } t_deq_meta;

endpackage

`default_nettype wire

@@ hw/rtl/cdeq_ctrl.sv @@
// Head pointer and occupancy of the ring; decodes each operation into store
// write/read addresses and the result status. Uses cdeq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_ctrl #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4,
    parameter int CNT_W = 5
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_accept,
    input  wire logic [2:0]          i_op,
    input  wire logic [3:0]          i_position,
    output logic                     o_wr_en,
    output logic [PTR_W-1:0]         o_wr_addr,
    output logic [PTR_W-1:0]         o_rd_addr,
    output cdeq_pkg::t_deq_meta      o_meta
);
    import cdeq_pkg::*;

    localparam int CMP_W = (CNT_W > 4) ? CNT_W : 4;

    logic [PTR_W-1:0] r_head, n_head;
    logic [CNT_W-1:0] r_occ, n_occ;

    logic             full, empty;
    logic [CNT_W-1:0] occ_m1;
    logic [PTR_W-1:0] head_dec, head_inc, back_slot, last_slot, pos_slot;
    logic             pos_beyond;

    // (a + b) mod DEPTH for a, b < DEPTH
    function automatic logic [PTR_W-1:0] ring_add(input logic [PTR_W-1:0] a,
                                                  input logic [PTR_W-1:0] b);
        logic [PTR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (PTR_W + 1)'(DEPTH)) begin
            s = s - (PTR_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

    assign full       = (r_occ == CNT_W'(DEPTH));
    assign empty      = (r_occ == '0);
    assign occ_m1     = r_occ - CNT_W'(1);
    assign head_dec   = (r_head == '0) ? PTR_W'(DEPTH - 1) : r_head - PTR_W'(1);
    assign head_inc   = ring_add(r_head, PTR_W'(1));
    assign back_slot  = ring_add(r_head, r_occ[PTR_W-1:0]);
    assign last_slot  = ring_add(r_head, occ_m1[PTR_W-1:0]);
    assign pos_slot   = ring_add(r_head, PTR_W'(i_position));
    assign pos_beyond = (CMP_W'(i_position) >= CMP_W'(r_occ));

    always_comb begin
        n_head           = r_head;
        n_occ            = r_occ;
        o_wr_en          = 1'b0;
        o_wr_addr        = back_slot;
        o_rd_addr        = r_head;
        o_meta.have_read = 1'b0;
        o_meta.status    = ST_OK;
        unique case (i_op)
            OP_PUSH_FRONT: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_head    = head_dec;
                    n_occ     = r_occ + CNT_W'(1);
                    o_wr_en   = 1'b1;
                    o_wr_addr = head_dec;
                end
            end
            OP_PUSH_BACK: begin
                if (full) begin
                    o_meta.status = ST_FULL;
                end else begin
                    n_occ   = r_occ + CNT_W'(1);
                    o_wr_en = 1'b1;
                end
            end
            OP_POP_FRONT: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    n_head = head_inc;
                    n_occ  = occ_m1;
                end
            end
            OP_POP_BACK: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    n_occ = occ_m1;
                end
            end
            OP_RD_FRONT: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_meta.have_read = 1'b1;
                end
            end
            OP_RD_BACK: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else begin
                    o_rd_addr        = last_slot;
                    o_meta.have_read = 1'b1;
                end
            end
            OP_RD_INDEX: begin
                if (empty) begin
                    o_meta.status = ST_EMPTY;
                end else if (pos_beyond) begin
                    o_meta.status = ST_RANGE;
                end else begin
                    o_rd_addr        = pos_slot;
                    o_meta.have_read = 1'b1;
                end
            end
            OP_CLEAR: begin
                n_head = '0;
                n_occ  = '0;
            end
            default: begin
                n_head = r_head;
            end
        endcase
        // count after the operation, low bits only
        o_meta.fill_count = FILL_W'(n_occ);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head <= '0;
            r_occ  <= '0;
        end else if (i_accept) begin
            r_head <= n_head;
            r_occ  <= n_occ;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/cdeq_store.sv @@
// Entry store of the ring: one write port, one read port, registered read data.
// Uses cdeq_pkg for the entry width.
`timescale 1ns / 1ps
`default_nettype none

module cdeq_store #(
    parameter int DEPTH = 16,
    parameter int PTR_W = 4
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_wr_en,
    input  wire logic [PTR_W-1:0]              i_wr_addr,
    input  wire logic [cdeq_pkg::ENTRY_W-1:0]  i_wr_data,
    input  wire logic                          i_rd_en,
    input  wire logic [PTR_W-1:0]              i_rd_addr,
    output logic      [cdeq_pkg::ENTRY_W-1:0]  o_rd_data
);
    import cdeq_pkg::*;

    logic [ENTRY_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/circular_deque.sv @@
// Circular deque: a beat enters stage 1 with its registered store read, then
// the output register. One operation per cycle while output ready is
// high; one access per port per cycle. Input ready follows it combinationally.
// Reset (synchronous, active low) empties the queue: head and count to zero;
// stored entries are left as they are and are never read before written.
`timescale 1ns / 1ps
`default_nettype none

module circular_deque #(
    parameter int DEPTH = 16
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // op[2:0], entry_id[34:3], entry_name_low[98:35], entry_name_high[114:99],
    // position[118:115], zero pad[119]
    input  wire logic [119:0] i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    // read_id[31:0], read_name_low[95:32], read_name_high[111:96],
    // fill_count[116:112], status[118:117], zero pad[119]
    output logic      [119:0] o_m_axis_tdata
);
    import cdeq_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic                  accept, advance;
    logic [2:0]            in_op;
    logic [ID_W-1:0]       in_id;
    logic [NAME_LO_W-1:0]  in_name_lo;
    logic [NAME_HI_W-1:0]  in_name_hi;
    logic [3:0]            in_position;

    logic                  wr_en;
    logic [PTR_W-1:0]      wr_addr, rd_addr;
    t_deq_meta             meta;
    logic [ENTRY_W-1:0]    rd_data;

    logic                  r_s1_valid;
    t_deq_meta             r_s1_meta;

    logic                  r_out_valid;
    logic [ID_W-1:0]       r_out_id;
    logic [NAME_LO_W-1:0]  r_out_name_lo;
    logic [NAME_HI_W-1:0]  r_out_name_hi;
    logic [FILL_W-1:0]     r_out_fill;
    logic [1:0]            r_out_status;

    assign in_op       = i_s_axis_tdata[2:0];
    assign in_id       = i_s_axis_tdata[34:3];
    assign in_name_lo  = i_s_axis_tdata[98:35];
    assign in_name_hi  = i_s_axis_tdata[114:99];
    assign in_position = i_s_axis_tdata[118:115];

    // stage 1 moves on when the output register is free or being drained
    assign advance         = r_s1_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_s1_valid || advance;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    cdeq_ctrl #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W),
        .CNT_W (CNT_W)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_accept   (accept),
        .i_op       (in_op),
        .i_position (in_position),
        .o_wr_en    (wr_en),
        .o_wr_addr  (wr_addr),
        .o_rd_addr  (rd_addr),
        .o_meta     (meta)
    );

    cdeq_store #(
        .DEPTH (DEPTH),
        .PTR_W (PTR_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (accept && wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data ({in_name_hi, in_name_lo, in_id}),
        .i_rd_en   (accept),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (advance) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_meta <= meta;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // read fields are zero unless the beat actually read an entry
    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_id      <= r_s1_meta.have_read ? rd_data[ID_W-1:0] : '0;
            r_out_name_lo <= r_s1_meta.have_read ?
                             rd_data[ID_W +: NAME_LO_W] : '0;
            r_out_name_hi <= r_s1_meta.have_read ?
                             rd_data[ID_W + NAME_LO_W +: NAME_HI_W] : '0;
            r_out_fill    <= r_s1_meta.fill_count;
            r_out_status  <= r_s1_meta.status;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out_status, r_out_fill, r_out_name_hi,
                              r_out_name_lo, r_out_id};

`ifndef SYNTHESIS
    a_read_only_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_s1_meta.have_read |-> r_s1_meta.status == ST_OK)
        else $error("read issued with non-ok status");

    a_full_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_FULL |-> r_out_fill == FILL_W'(DEPTH))
        else $error("push rejected while count below depth");

    a_empty_fill: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_status == ST_EMPTY |-> r_out_fill == '0)
        else $error("empty status with nonzero count");

    a_accept_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> r_s1_valid)
        else $error("accepted beat lost before stage 1");
`endif

endmodule

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the circular deque: drives op beats on the input stream,
// predicts each result beat with its own deque model and checks every field of every beat.
// Depends on cdeq_pkg (op and status codes) and the circular_deque top level.
`timescale 1ns / 1ps

module tb_top;
    import cdeq_pkg::*;

    localparam int DEPTH       = 16;
    localparam int CYCLE_LIMIT = 200000;
    localparam int TAIL_CYCLES = 12;
    localparam int LONG_HOLD   = 120;

    // input beat, lowest field last in the list
    typedef struct packed {
        logic               pad;
        logic [3:0]         position;
        logic [15:0]        name_hi;
        logic [63:0]        name_lo;
        logic signed [31:0] id;
        logic [2:0]         op;
    } t_deq_cmd;

    // result beat
    typedef struct packed {
        logic               pad;
        logic [1:0]         status;
        logic [4:0]         fill_count;
        logic [15:0]        name_hi;
        logic [63:0]        name_lo;
        logic signed [31:0] id;
    } t_deq_res;

    typedef enum int {MIX_FILL, MIX_DRAIN, MIX_EVEN} t_mix;

    logic         i_clk           = 1'b0;
    logic         i_rst_n         = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic [119:0] i_s_axis_tdata  = '0;
    logic         i_m_axis_tready = 1'b0;
    logic         o_s_axis_tready;
    logic         o_m_axis_tvalid;
    logic [119:0] o_m_axis_tdata;

    circular_deque #(.DEPTH(DEPTH)) dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    // deque model state
    logic [31:0] dq_id [DEPTH];
    logic [63:0] dq_lo [DEPTH];
    logic [15:0] dq_hi [DEPTH];
    int          dq_head  = 0;
    int          dq_count = 0;

    t_deq_res pending_results[$];
    int       err_count   = 0;
    int       beat_count  = 0;
    int       cycle_count = 0;
    bit       idle_on     = 1'b1;
    bit       rx_long_hold = 1'b0;
    int       rx_stall_left = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("MISMATCH beat %0d %s: got %0h want %0h", beat_count, what, got, want);
        err_count++;
    endtask

    function automatic void store_entry(input int slot, input t_deq_cmd c);
        dq_id[slot] = c.id;
        dq_lo[slot] = c.name_lo;
        dq_hi[slot] = c.name_hi;
    endfunction

    // applies one op to the model and returns the beat the block should give
    function automatic t_deq_res deque_apply(input t_deq_cmd c);
        t_deq_res r;
        int       slot;
        bit       have_read;
        r = '0;
        slot = 0;
        have_read = 1'b0;
        r.status = ST_OK;
        case (c.op)
            OP_PUSH_FRONT: begin
                if (dq_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    dq_head = (dq_head + DEPTH - 1) % DEPTH;
                    store_entry(dq_head, c);
                    dq_count++;
                end
            end
            OP_PUSH_BACK: begin
                if (dq_count >= DEPTH) begin
                    r.status = ST_FULL;
                end else begin
                    store_entry((dq_head + dq_count) % DEPTH, c);
                    dq_count++;
                end
            end
            OP_POP_FRONT: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    dq_head = (dq_head + 1) % DEPTH;
                    dq_count--;
                end
            end
            OP_POP_BACK: begin
                if (dq_count == 0) r.status = ST_EMPTY;
                else dq_count--;
            end
            OP_RD_FRONT, OP_RD_BACK: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else begin
                    slot = (c.op == OP_RD_FRONT) ? dq_head
                                                 : (dq_head + dq_count - 1) % DEPTH;
                    have_read = 1'b1;
                end
            end
            OP_RD_INDEX: begin
                if (dq_count == 0) begin
                    r.status = ST_EMPTY;
                end else if (int'(c.position) >= dq_count) begin
                    r.status = ST_RANGE;
                end else begin
                    slot = (dq_head + int'(c.position)) % DEPTH;
                    have_read = 1'b1;
                end
            end
            default: begin
                dq_head = 0;
                dq_count = 0;
            end
        endcase
        if (have_read) begin
            r.id = dq_id[slot];
            r.name_lo = dq_lo[slot];
            r.name_hi = dq_hi[slot];
        end
        r.fill_count = dq_count[4:0];
        return r;
    endfunction

    function automatic t_deq_cmd make_cmd(input logic [2:0] op, input logic [31:0] id,
                                          input logic [63:0] lo, input logic [15:0] hi,
                                          input logic [3:0] pos);
        t_deq_cmd c;
        c = '0;
        c.op = op;
        c.id = id;
        c.name_lo = lo;
        c.name_hi = hi;
        c.position = pos;
        return c;
    endfunction

    // random payload; at least half the indexed reads land inside a nonempty fill
    function automatic t_deq_cmd rand_cmd(input logic [2:0] op);
        logic [3:0] pos;
        if ($urandom_range(0, 1) == 0 && dq_count > 0)
            pos = 4'($urandom_range(0, dq_count - 1));
        else
            pos = 4'($urandom_range(0, 15));
        return make_cmd(op, $urandom, {$urandom, $urandom},
                        16'($urandom_range(0, 65535)), pos);
    endfunction

    function automatic logic [2:0] pick_op(input t_mix mode);
        int r;
        int push_w;
        int pop_w;
        r = $urandom_range(0, 99);
        push_w = (mode == MIX_FILL) ? 55 : (mode == MIX_DRAIN) ? 20 : 35;
        pop_w  = (mode == MIX_FILL) ? 15 : (mode == MIX_DRAIN) ? 50 : 30;
        if (r < push_w) return ($urandom_range(0, 1) != 0) ? OP_PUSH_BACK : OP_PUSH_FRONT;
        if (r < push_w + pop_w) return ($urandom_range(0, 1) != 0) ? OP_POP_BACK : OP_POP_FRONT;
        if (r >= 98) return OP_CLEAR;
        case ($urandom_range(0, 2))
            0: return OP_RD_FRONT;
            1: return OP_RD_BACK;
            default: return OP_RD_INDEX;
        endcase
    endfunction

    // offer one beat, wait for the handshake, then record the expected result
    task automatic send_beat(input t_deq_cmd c);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= c;
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
        pending_results.insert(pending_results.size(), deque_apply(c));
    endtask

    task automatic drain_results();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_edge_cases();
        send_beat(make_cmd(OP_POP_FRONT, '0, '0, '0, '0));
        send_beat(make_cmd(OP_RD_INDEX, '0, '0, '0, 4'hf));
        send_beat(make_cmd(OP_PUSH_FRONT, 32'h8000_0000, '1, '1, '0));
        send_beat(make_cmd(OP_PUSH_BACK, 32'h7fff_ffff, '0, '0, '1));
        send_beat(make_cmd(OP_RD_FRONT, '1, '1, '1, '1));
        send_beat(make_cmd(OP_RD_BACK, '0, '0, '0, '0));
        send_beat(make_cmd(OP_RD_INDEX, '0, '0, '0, 4'd1));
        send_beat(make_cmd(OP_RD_INDEX, '0, '0, '0, 4'd2));
        send_beat(make_cmd(OP_POP_BACK, '0, '0, '0, '0));
        send_beat(make_cmd(OP_POP_FRONT, '0, '0, '0, '0));
        send_beat(make_cmd(OP_POP_BACK, '0, '0, '0, '0));
        send_beat(make_cmd(OP_RD_FRONT, '0, '0, '0, '0));
        send_beat(make_cmd(OP_RD_BACK, '0, '0, '0, '0));
        send_beat(make_cmd(OP_CLEAR, '1, '1, '1, '1));
    endtask

    // receiver holds off while the queue is filled past full, then the sender waits out
    task automatic test_backpressure();
        rx_long_hold = 1'b1;
        send_beat(rand_cmd(OP_CLEAR));
        for (int i = 0; i < DEPTH; i++)
            send_beat(rand_cmd((i % 3 == 0) ? OP_PUSH_FRONT : OP_PUSH_BACK));
        send_beat(rand_cmd(OP_PUSH_FRONT));
        send_beat(rand_cmd(OP_PUSH_BACK));
        send_beat(make_cmd(OP_RD_INDEX, '0, '0, '0, 4'd15));
        send_beat(make_cmd(OP_RD_INDEX, '0, '0, '0, 4'd0));
        send_beat(rand_cmd(OP_RD_BACK));
        send_beat(rand_cmd(OP_POP_FRONT));
        send_beat(rand_cmd(OP_POP_BACK));
        drain_results();
    endtask

    task automatic test_random_mix(input int n_items, input bit with_gaps);
        t_mix mode;
        mode = MIX_EVEN;
        idle_on = with_gaps;
        for (int i = 0; i < n_items; i++) begin
            if (i % 48 == 0) mode = t_mix'($urandom_range(0, 2));
            if (with_gaps && i % 100 == 0) idle_on = ($urandom_range(0, 3) != 0);
            send_beat(rand_cmd(pick_op(mode)));
        end
        drain_results();
    endtask

    // result side: random stall bursts plus one long hold on request
    initial begin
        forever begin
            @(posedge i_clk);
            if (rx_stall_left == 0) begin
                if (rx_long_hold) begin
                    rx_long_hold = 1'b0;
                    rx_stall_left = LONG_HOLD;
                end else if (idle_on && $urandom_range(0, 5) == 0) begin
                    rx_stall_left = $urandom_range(1, 7);
                end
            end
            if (rx_stall_left > 0) begin
                rx_stall_left--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_deq_res got;
        t_deq_res want;
        got = o_m_axis_tdata;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            beat_count++;
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", got[63:0], '0);
            end else begin
                want = pending_results[0];
                pending_results.delete(0);
                if (got.id !== want.id)
                    report_mismatch("read_id", 64'(got.id), 64'(want.id));
                if (got.name_lo !== want.name_lo)
                    report_mismatch("read_name_low", got.name_lo, want.name_lo);
                if (got.name_hi !== want.name_hi)
                    report_mismatch("read_name_high", 64'(got.name_hi), 64'(want.name_hi));
                if (got.fill_count !== want.fill_count)
                    report_mismatch("fill_count", 64'(got.fill_count),
                                    64'(want.fill_count));
                if (got.status !== want.status)
                    report_mismatch("status", 64'(got.status), 64'(want.status));
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_edge_cases();
        test_backpressure();
        test_random_mix(1600, 1'b1);
        test_random_mix(320, 1'b0);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0 && pending_results.size() == 0) $display("simulation ok");
        else $display("simulation failed");
        $finish;
    end

endmodule
